### hdl/mvi_pkg.sv
// ============================================================================
// mvi_pkg
// Shared types, sizes and helpers for the value iteration block.
// ============================================================================
package mvi_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_ACTIONS = 4;
    localparam int VALUE_BITS  = 40;
    localparam int STATE_W     = 4;
    localparam int ACTION_W    = 2;
    localparam int ADDR_W      = STATE_W + ACTION_W + STATE_W;
    localparam int TABLE_DEPTH = MAX_STATES * MAX_ACTIONS * MAX_STATES;
    localparam int PROB_W      = 17;
    localparam int REWARD_W    = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int SUM_W       = 44;

    localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

    typedef enum logic [1:0] {
        MODE_LOAD_PROB   = 2'd0,
        MODE_LOAD_REWARD = 2'd1,
        MODE_START       = 2'd2,
        MODE_NONE        = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_DISCOUNT     = 3'd0,
        REG_HORIZON      = 3'd1,
        REG_STATES_USED  = 3'd2,
        REG_ACTIONS_USED = 3'd3,
        REG_TOLERANCE    = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_D,
        ST_TERM,
        ST_MUL_P,
        ST_ACC,
        ST_CMP,
        ST_SWEEP_END,
        ST_OUT
    } state_t;

    // Saturate a wide signed sum to the value width.
    function automatic logic signed [VALUE_BITS-1:0] sat_value(
        input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [VALUE_BITS-1:0] r;
        begin
            hi = SUM_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
            lo = -hi - SUM_W'(1);
            if (x > hi)
                r = hi[VALUE_BITS-1:0];
            else if (x < lo)
                r = lo[VALUE_BITS-1:0];
            else
                r = x[VALUE_BITS-1:0];
            return r;
        end
    endfunction

endpackage

### hdl/mdp_value_iteration.sv
// ============================================================================
// mdp_value_iteration
// Fixed-point value iteration over a loaded Markov decision process.
// ============================================================================
// Table loads are accepted back to back while the block is idle.
// A start request runs sweeps, each state * action * state term passing through
// the READ, MUL_D, TERM, MUL_P and ACC steps, then a change check over the states
// and a sweep closing step per sweep. A policy pass over the same terms follows,
// and each result then waits in the result register until the sink takes it.
// Reset (rst_n, asynchronous) idles the block, zeroes values, restores defaults.
module mdp_value_iteration
    import mvi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // from_state[3:0], action[5:4], to_state[9:6], entry_value[41:10], zero pad
    input  logic [47:0]           s_tdata,
    // mode[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // state_index[3:0], state_value[43:4], chosen_action[45:44], zero pad
    output logic [47:0]           m_tdata,
    // converged[0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef logic signed [VALUE_BITS-1:0] value_t;

    // Configuration registers.
    logic [16:0] discount_reg;
    logic [15:0] horizon_reg;
    logic [4:0]  states_used_reg;
    logic [2:0]  actions_used_reg;
    logic [15:0] tolerance_reg;

    // Sequencer state.
    state_t               state_reg, state_next;
    logic [STATE_W-1:0]   s_reg, s_next;
    logic [ACTION_W-1:0]  a_reg, a_next;
    logic [STATE_W-1:0]   t_reg, t_next;
    logic                 pol_reg, pol_next;
    logic [STATE_W-1:0]   n_last_reg, n_last_next;
    logic [ACTION_W-1:0]  na_last_reg, na_last_next;
    logic [PROB_W-1:0]    disc_reg, disc_next;
    value_t               acc_reg, acc_next;
    value_t               best_reg, best_next;
    logic [ACTION_W-1:0]  besta_reg, besta_next;
    value_t               term_reg, term_next;
    logic [VALUE_BITS:0]  worst_reg, worst_next;
    logic [15:0]          sweep_reg, sweep_next;
    logic                 conv_reg, conv_next;
    value_t               old_reg [MAX_STATES];
    value_t               old_next [MAX_STATES];
    value_t               new_reg [MAX_STATES];
    value_t               new_next [MAX_STATES];

    // Shared multiplier partial products.
    logic signed [41:0]   pp_hi_reg, pp_hi_next;
    logic [32:0]          pp_lo_reg, pp_lo_next;

    // Result register.
    logic                 ov_reg, ov_next;
    logic [STATE_W-1:0]   oidx_reg, oidx_next;
    value_t               oval_reg, oval_next;
    logic [ACTION_W-1:0]  oba_reg, oba_next;
    logic                 olast_reg, olast_next;

    // Table memories with registered read data.
    logic [PROB_W-1:0]    prob_mem [TABLE_DEPTH];
    logic [REWARD_W-1:0]  rew_mem [TABLE_DEPTH];
    logic [PROB_W-1:0]    prob_rd_reg;
    logic [REWARD_W-1:0]  rew_rd_reg;

    logic                 in_fire;
    mode_t                in_mode;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic signed [31:0]   in_value;
    logic [PROB_W-1:0]    in_prob;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign in_mode   = mode_t'(s_tuser);
    assign wr_addr   = {s_tdata[3:0], s_tdata[5:4], s_tdata[9:6]};
    assign in_value  = s_tdata[41:10];
    assign rd_addr   = {s_reg, a_reg, t_reg};

    // Probability loads clip to the range 0 .. 1.0.
    always_comb
    begin
        if (in_value < 32'sd0)
            in_prob = '0;
        else if (in_value > 32'sd65536)
            in_prob = PROB_ONE;
        else
            in_prob = in_value[PROB_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_mode == MODE_LOAD_PROB))
            prob_mem[wr_addr] <= in_prob;
        prob_rd_reg <= prob_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_mode == MODE_LOAD_REWARD))
            rew_mem[wr_addr] <= in_value;
        rew_rd_reg <= rew_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg     <= 17'd65536;
            horizon_reg      <= 16'd100;
            states_used_reg  <= 5'd16;
            actions_used_reg <= 3'd4;
            tolerance_reg    <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DISCOUNT:     discount_reg     <= cfg_data;
                REG_HORIZON:      horizon_reg      <= cfg_data[15:0];
                REG_STATES_USED:  states_used_reg  <= cfg_data[4:0];
                REG_ACTIONS_USED: actions_used_reg <= cfg_data[2:0];
                REG_TOLERANCE:    tolerance_reg    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // The shared multiplier computes round(x * q / 65536) from two partial
    // products: the signed upper part of x and the unsigned low 16 bits.
    logic [PROB_W-1:0]     mul_q;
    value_t                mul_x;
    logic signed [SUM_W-1:0] mul_res;
    logic [33:0]           lo_round;

    always_comb
    begin
        if (state_reg == ST_MUL_D)
        begin
            mul_q = disc_reg;
            mul_x = old_reg[t_reg];
        end
        else
        begin
            mul_q = prob_rd_reg;
            mul_x = term_reg;
        end
        pp_hi_next = 42'($signed(mul_x[VALUE_BITS-1:16]) * $signed({1'b0, mul_q}));
        pp_lo_next = 33'(mul_q * mul_x[15:0]);
        lo_round   = {1'b0, pp_lo_reg} + 34'd32768;
        mul_res    = SUM_W'(pp_hi_reg) + SUM_W'(lo_round[33:16]);
    end

    // Sequencer.
    logic signed [SUM_W-1:0] term_sum;
    logic signed [SUM_W-1:0] acc_sum;
    value_t                  acc_sat;
    logic                    upd;
    value_t                  fbest;
    logic [ACTION_W-1:0]     fba;
    value_t                  cmp_new;
    value_t                  cmp_old;
    logic [VALUE_BITS:0]     diff;
    logic [STATE_W-1:0]      ord_sel;

    always_comb
    begin
        state_next   = state_reg;
        s_next       = s_reg;
        a_next       = a_reg;
        t_next       = t_reg;
        pol_next     = pol_reg;
        n_last_next  = n_last_reg;
        na_last_next = na_last_reg;
        disc_next    = disc_reg;
        acc_next     = acc_reg;
        best_next    = best_reg;
        besta_next   = besta_reg;
        term_next    = term_reg;
        worst_next   = worst_reg;
        sweep_next   = sweep_reg;
        conv_next    = conv_reg;
        old_next     = old_reg;
        new_next     = new_reg;
        ov_next      = ov_reg;
        oidx_next    = oidx_reg;
        oval_next    = oval_reg;
        oba_next     = oba_reg;
        olast_next   = olast_reg;

        ord_sel  = ((state_reg == ST_CMP) || (state_reg == ST_ACC)) ? s_reg : t_reg;
        cmp_old  = old_reg[ord_sel];
        cmp_new  = new_reg[s_reg];
        diff     = (cmp_new >= cmp_old)
                 ? (VALUE_BITS+1)'({cmp_new[VALUE_BITS-1], cmp_new}
                                   - {cmp_old[VALUE_BITS-1], cmp_old})
                 : (VALUE_BITS+1)'({cmp_old[VALUE_BITS-1], cmp_old}
                                   - {cmp_new[VALUE_BITS-1], cmp_new});
        term_sum = mul_res + SUM_W'($signed(rew_rd_reg));
        acc_sum  = mul_res + SUM_W'(acc_reg);
        acc_sat  = sat_value(acc_sum);
        upd      = (a_reg == '0) || (acc_sat > best_reg);
        fbest    = upd ? acc_sat : best_reg;
        fba      = upd ? a_reg : besta_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_mode == MODE_START))
                begin
                    for (int i = 0; i < MAX_STATES; i++)
                    begin
                        old_next[i] = '0;
                        new_next[i] = '0;
                    end
                    sweep_next = '0;
                    conv_next  = 1'b0;
                    worst_next = '0;
                    acc_next   = '0;
                    s_next     = '0;
                    a_next     = '0;
                    t_next     = '0;
                    if (states_used_reg == 5'd0)
                        n_last_next = '0;
                    else if (states_used_reg > 5'(MAX_STATES))
                        n_last_next = STATE_W'(MAX_STATES - 1);
                    else
                        n_last_next = STATE_W'(states_used_reg - 5'd1);
                    if (actions_used_reg == 3'd0)
                        na_last_next = '0;
                    else if (actions_used_reg > 3'(MAX_ACTIONS))
                        na_last_next = ACTION_W'(MAX_ACTIONS - 1);
                    else
                        na_last_next = ACTION_W'(actions_used_reg - 3'd1);
                    disc_next  = (discount_reg > PROB_ONE) ? PROB_ONE : discount_reg;
                    pol_next   = (horizon_reg == 16'd0);
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_TERM;
            ST_TERM:
            begin
                term_next  = sat_value(term_sum);
                state_next = ST_MUL_P;
            end
            ST_MUL_P: state_next = ST_ACC;
            ST_ACC:
            begin
                if (t_reg != n_last_reg)
                begin
                    acc_next   = acc_sat;
                    t_next     = t_reg + 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    best_next  = fbest;
                    besta_next = fba;
                    acc_next   = '0;
                    t_next     = '0;
                    if (a_reg != na_last_reg)
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = ST_READ;
                    end
                    else if (pol_reg)
                    begin
                        oidx_next  = s_reg;
                        oval_next  = cmp_old;
                        oba_next   = fba;
                        olast_next = (s_reg == n_last_reg);
                        ov_next    = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        new_next[s_reg] = fbest;
                        a_next          = '0;
                        if (s_reg != n_last_reg)
                        begin
                            s_next     = s_reg + 1'b1;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            s_next     = '0;
                            state_next = ST_CMP;
                        end
                    end
                end
            end
            ST_CMP:
            begin
                // Compare first, then take the new value as the old one.
                if (diff > worst_reg)
                    worst_next = diff;
                old_next[s_reg] = cmp_new;
                if (s_reg != n_last_reg)
                    s_next = s_reg + 1'b1;
                else
                begin
                    s_next     = '0;
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END:
            begin
                sweep_next = sweep_reg + 16'd1;
                worst_next = '0;
                s_next     = '0;
                a_next     = '0;
                t_next     = '0;
                state_next = ST_READ;
                if (worst_reg < (VALUE_BITS+1)'(tolerance_reg))
                begin
                    conv_next = 1'b1;
                    pol_next  = 1'b1;
                end
                else if (sweep_next >= horizon_reg)
                    pol_next = 1'b1;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    ov_next = 1'b0;
                    a_next  = '0;
                    t_next  = '0;
                    if (olast_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            s_reg       <= '0;
            a_reg       <= '0;
            t_reg       <= '0;
            pol_reg     <= 1'b0;
            n_last_reg  <= '0;
            na_last_reg <= '0;
            disc_reg    <= '0;
            worst_reg   <= '0;
            sweep_reg   <= '0;
            conv_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            for (int i = 0; i < MAX_STATES; i++)
            begin
                old_reg[i] <= '0;
                new_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            s_reg       <= s_next;
            a_reg       <= a_next;
            t_reg       <= t_next;
            pol_reg     <= pol_next;
            n_last_reg  <= n_last_next;
            na_last_reg <= na_last_next;
            disc_reg    <= disc_next;
            worst_reg   <= worst_next;
            sweep_reg   <= sweep_next;
            conv_reg    <= conv_next;
            ov_reg      <= ov_next;
            old_reg     <= old_next;
            new_reg     <= new_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        besta_reg <= besta_next;
        term_reg  <= term_next;
        pp_hi_reg <= pp_hi_next;
        pp_lo_reg <= pp_lo_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        oba_reg   <= oba_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oba_reg, oval_reg, oidx_reg};
    assign m_tuser  = conv_reg;
    assign m_tlast  = olast_reg;

    // A result is only shown while the block refuses new requests.
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("result valid while accepting requests");

    // The last result always names the last used state.
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == n_last_reg))
        else $error("last flag on wrong state");

    // Convergence can only be flagged after at least one sweep.
    a_conv_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        conv_reg |-> (sweep_reg != 16'd0))
        else $error("converged without a sweep");

endmodule

### verif/value_iteration_checker.sv
// ============================================================================
// value_iteration_checker
// Watches the request, result and register channels of the value iteration
// block, predicts the per-state results of every start request and compares
// them field by field with what the block delivers.
// ============================================================================
module value_iteration_checker
    import mvi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [47:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [47:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_seen
);

    typedef struct {
        logic [STATE_W-1:0]           state_index;
        logic signed [VALUE_BITS-1:0] state_value;
        logic [ACTION_W-1:0]          chosen_action;
        logic                         converged;
        logic                         last;
    } state_result_t;

    state_result_t expected_states[$];

    logic [PROB_W-1:0] prob_tab[TABLE_DEPTH];
    int                reward_tab[TABLE_DEPTH];
    longint            cur_vals[MAX_STATES];

    int discount_reg, horizon_reg, states_reg, actions_reg, tolerance_reg;

    localparam longint VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;

    function automatic longint clamp_value(input longint x);
        if (x > VMAX)
            return VMAX;
        if (x < -VMAX - 1)
            return -VMAX - 1;
        return x;
    endfunction

    // Q1.16 scaling with round half up; t is split so the product stays small.
    function automatic longint scale_q16(input longint q, input longint t);
        longint hi;
        longint lo;
        hi = t >>> 16;
        lo = t & 64'hFFFF;
        return hi * q + ((q * lo + 32768) >>> 16);
    endfunction

    function automatic longint expected_return(input int s, input int a, input longint disc,
                                               input int n);
        longint acc;
        longint term;
        int     idx;
        acc = 0;
        for (int t = 0; t < n; t++)
        begin
            idx  = (s * MAX_ACTIONS + a) * MAX_STATES + t;
            term = clamp_value(scale_q16(disc, cur_vals[t]) + longint'(reward_tab[idx]));
            acc  = clamp_value(acc + scale_q16(longint'(prob_tab[idx]), term));
        end
        return acc;
    endfunction

    task automatic predict_iteration();
        int            n;
        int            na;
        int            sweeps;
        int            ba;
        longint        disc;
        longint        best;
        longint        v;
        longint        worst;
        longint        d;
        logic          conv;
        longint        nxt[MAX_STATES];
        state_result_t r;
        n    = (states_reg < 1) ? 1 : (states_reg > MAX_STATES) ? MAX_STATES : states_reg;
        na   = (actions_reg < 1) ? 1 : (actions_reg > MAX_ACTIONS) ? MAX_ACTIONS : actions_reg;
        disc = (discount_reg > 65536) ? 65536 : discount_reg;
        for (int i = 0; i < MAX_STATES; i++)
            cur_vals[i] = 0;
        sweeps = 0;
        conv   = 1'b0;
        while (sweeps < horizon_reg && !conv)
        begin
            for (int s = 0; s < n; s++)
            begin
                best = expected_return(s, 0, disc, n);
                for (int a = 1; a < na; a++)
                begin
                    v = expected_return(s, a, disc, n);
                    if (v > best)
                        best = v;
                end
                nxt[s] = best;
            end
            // The change is measured against the previous sweep before copying.
            worst = 0;
            for (int s = 0; s < n; s++)
            begin
                d = (nxt[s] >= cur_vals[s]) ? nxt[s] - cur_vals[s] : cur_vals[s] - nxt[s];
                if (d > worst)
                    worst = d;
            end
            for (int s = 0; s < n; s++)
                cur_vals[s] = nxt[s];
            sweeps++;
            if (worst < longint'(tolerance_reg))
                conv = 1'b1;
        end
        for (int s = 0; s < n; s++)
        begin
            best = expected_return(s, 0, disc, n);
            ba   = 0;
            for (int a = 1; a < na; a++)
            begin
                v = expected_return(s, a, disc, n);
                if (v > best)
                begin
                    best = v;
                    ba   = a;
                end
            end
            r.state_index   = s[STATE_W-1:0];
            r.state_value   = cur_vals[s][VALUE_BITS-1:0];
            r.chosen_action = ba[ACTION_W-1:0];
            r.converged     = conv;
            r.last          = (s + 1 == n);
            expected_states.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        state_result_t    want;
        logic [STATE_W-1:0] fs;
        logic [STATE_W-1:0] ts;
        logic [ACTION_W-1:0] ac;
        int               ev;
        int               idx;
        if (!rst_n)
        begin
            discount_reg  = 65536;
            horizon_reg   = 100;
            states_reg    = 16;
            actions_reg   = 4;
            tolerance_reg = 1;
            expected_states.delete();
            mismatches   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DISCOUNT:     discount_reg  = cfg_data;
                    REG_HORIZON:      horizon_reg   = cfg_data[15:0];
                    REG_STATES_USED:  states_reg    = cfg_data[4:0];
                    REG_ACTIONS_USED: actions_reg   = cfg_data[2:0];
                    REG_TOLERANCE:    tolerance_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                fs  = s_tdata[3:0];
                ac  = s_tdata[5:4];
                ts  = s_tdata[9:6];
                ev  = s_tdata[41:10];
                idx = (int'(fs) * MAX_ACTIONS + int'(ac)) * MAX_STATES + int'(ts);
                case (mode_t'(s_tuser))
                    MODE_LOAD_PROB:
                        prob_tab[idx] = (ev < 0) ? '0 : (ev > 65536) ? PROB_ONE : ev[PROB_W-1:0];
                    MODE_LOAD_REWARD:
                        reward_tab[idx] = ev;
                    MODE_START:
                        predict_iteration();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_states.size() == 0)
                begin
                    $error("result with no prediction waiting: state_index %0d", m_tdata[3:0]);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (m_tdata[3:0] !== want.state_index ||
                        $signed(m_tdata[43:4]) !== want.state_value ||
                        m_tdata[45:44] !== want.chosen_action ||
                        m_tuser !== want.converged || m_tlast !== want.last)
                        mismatches <= mismatches + 1;
                    if (m_tdata[3:0] !== want.state_index)
                        $error("state_index: expected %0d, got %0d", want.state_index, m_tdata[3:0]);
                    if ($signed(m_tdata[43:4]) !== want.state_value)
                        $error("state_value: expected %0d, got %0d", want.state_value,
                               $signed(m_tdata[43:4]));
                    if (m_tdata[45:44] !== want.chosen_action)
                        $error("chosen_action: expected %0d, got %0d", want.chosen_action,
                               m_tdata[45:44]);
                    if (m_tuser !== want.converged)
                        $error("converged: expected %0d, got %0d", want.converged, m_tuser);
                    if (m_tlast !== want.last)
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                end
            end
            outstanding <= expected_states.size();
        end
    end

endmodule

### verif/tb_mdp_value_iteration.sv
// ============================================================================
// tb_mdp_value_iteration
// Stimulus and verdict for the value iteration block.
// ============================================================================
// Table loads are sent with random gaps and the sink stalls at random. Before
// each start request every table entry that the sweep will read is loaded, so
// no undefined entry is ever read. Registers are only written once all
// predicted results have arrived and the block has had time to settle.
module tb_mdp_value_iteration;
    import mvi_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE       = 20;
    localparam int TOTAL_ITEMS  = 220;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int results_seen;

    // Which table entries hold a loaded value, and the current sizes in use.
    bit prob_loaded[TABLE_DEPTH];
    bit reward_loaded[TABLE_DEPTH];
    int states_raw;
    int actions_raw;

    int  cycle_count;
    int  load_count;
    int  start_count;
    int  items_sent;
    bit  steady;
    int  stall_left;

    mdp_value_iteration dut (.*);

    value_iteration_checker u_checker (.*);

    always #10 clk = ~clk;

    // Run limit reckoned well above the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sink back-pressure: mostly short stalls, a few long ones, no new ones when steady.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 5) == 0)
        begin
            stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 3);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (steady || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request; valid stays high when the next request follows at once.
    task automatic send_request(input mode_t mode, input int fs, input int ac, input int ts,
                                input logic [31:0] value);
        int gap;
        int idx;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= mode;
        s_tdata  <= {6'd0, value, ts[3:0], ac[1:0], fs[3:0]};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        idx = (fs * MAX_ACTIONS + ac) * MAX_STATES + ts;
        if (mode == MODE_LOAD_PROB)
            prob_loaded[idx] = 1'b1;
        if (mode == MODE_LOAD_REWARD)
            reward_loaded[idx] = 1'b1;
        if (mode == MODE_LOAD_PROB || mode == MODE_LOAD_REWARD)
            load_count++;
        if (mode == MODE_START)
            start_count++;
        items_sent++;
    endtask

    function automatic logic [31:0] random_prob();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return 32'd65536;
        return $urandom_range(0, 40000);
    endfunction

    function automatic logic [31:0] random_reward();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 2 ** 21) - 2 ** 20;
    endfunction

    // Waits until every predicted result has been taken, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Valid is left high so that register writes can follow back to back.
    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_STATES_USED)
            states_raw = value & 5'h1F;
        if (idx == REG_ACTIONS_USED)
            actions_raw = value & 3'h7;
    endtask

    task automatic configure(input int disc, input int hor, input int ns, input int na,
                             input int tol);
        drain();
        write_reg(REG_DISCOUNT, disc);
        write_reg(REG_HORIZON, hor);
        write_reg(REG_STATES_USED, ns);
        write_reg(REG_ACTIONS_USED, na);
        write_reg(REG_TOLERANCE, tol);
        cfg_valid <= 1'b0;
    endtask

    // Loads every entry the coming sweep reads that was never loaded, then starts.
    task automatic start_iteration();
        int n;
        int na;
        int idx;
        n  = (states_raw < 1) ? 1 : (states_raw > MAX_STATES) ? MAX_STATES : states_raw;
        na = (actions_raw < 1) ? 1 : (actions_raw > MAX_ACTIONS) ? MAX_ACTIONS : actions_raw;
        for (int s = 0; s < n; s++)
            for (int a = 0; a < na; a++)
                for (int t = 0; t < n; t++)
                begin
                    idx = (s * MAX_ACTIONS + a) * MAX_STATES + t;
                    if (!prob_loaded[idx])
                        send_request(MODE_LOAD_PROB, s, a, t, random_prob());
                    if (!reward_loaded[idx])
                        send_request(MODE_LOAD_REWARD, s, a, t, random_reward());
                end
        send_request(MODE_START, $urandom_range(0, 15), $urandom_range(0, 3),
                     $urandom_range(0, 15), $urandom);
    endtask

    initial
    begin
        int n;
        int kind;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_LOAD_PROB;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_DISCOUNT;
        cfg_data    = '0;
        cycle_count = 0;
        stall_left  = 0;
        steady      = 1'b0;
        states_raw  = 16;
        actions_raw = 4;
        load_count  = 0;
        start_count = 0;
        items_sent  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: discount above one saturates, all four actions, no tolerance.
        configure(131071, 3, 2, 4, 0);
        send_request(MODE_LOAD_PROB, 0, 0, 0, 32'hFFFF_FFFF);
        send_request(MODE_LOAD_PROB, 0, 0, 1, 32'h7FFF_FFFF);
        send_request(MODE_LOAD_PROB, 0, 1, 0, 32'd65536);
        send_request(MODE_LOAD_PROB, 1, 3, 1, 32'd65536);
        send_request(MODE_LOAD_REWARD, 0, 0, 0, 32'h8000_0000);
        send_request(MODE_LOAD_REWARD, 0, 1, 0, 32'h7FFF_FFFF);
        send_request(MODE_LOAD_REWARD, 1, 3, 1, 32'h7FFF_FFFF);
        send_request(MODE_LOAD_REWARD, 15, 3, 15, 32'h8000_0000);
        send_request(MODE_LOAD_PROB, 15, 3, 15, 32'd0);
        send_request(MODE_NONE, 15, 3, 15, 32'hFFFF_FFFF);
        start_iteration();

        // Horizon zero: no sweeps at all.
        configure(65536, 0, 2, 4, 1);
        start_iteration();

        // Zero counts act as one; huge tolerance converges at once over a long horizon.
        configure(0, 65535, 0, 0, 65535);
        start_iteration();

        // An oversized action count clamps to the maximum of four.
        steady = 1'b1;
        configure(65536, 2, 2, 7, 0);
        start_iteration();
        steady = 1'b0;

        // Random phases: small sizes, loads mostly inside the used range, then a start.
        while (items_sent < TOTAL_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            configure(($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                  : $urandom_range(40000, 65536),
                      $urandom_range(1, 6),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
                      $urandom_range(0, 5),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000));
            n = $urandom_range(2, 10);
            for (int i = 0; i < n; i++)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    send_request(MODE_NONE, $urandom_range(0, 15), $urandom_range(0, 3),
                                 $urandom_range(0, 15), $urandom);
                else if (kind < 5)
                    send_request(MODE_LOAD_PROB, $urandom_range(0, 3),
                                 $urandom_range(0, 3), $urandom_range(0, 3),
                                 random_prob());
                else if (kind < 9)
                    send_request(MODE_LOAD_REWARD, $urandom_range(0, 3),
                                 $urandom_range(0, 3), $urandom_range(0, 3),
                                 random_reward());
                else
                    send_request(MODE_LOAD_PROB, $urandom_range(0, 15),
                                 $urandom_range(0, 3), $urandom_range(0, 15),
                                 random_prob());
            end
            start_iteration();
        end

        drain();
        $display("Covered %0d table loads and %0d start requests, %0d state results checked.",
                 load_count, start_count, results_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
